FILE: src/tar_pkg.sv
package tar_pkg;

  // Alarm levels as seen on the result port
  typedef enum logic [2:0] {
    LVL_NOMINAL = 3'd0,
    LVL_HI      = 3'd1,
    LVL_HIHI    = 3'd2,
    LVL_LO      = 3'd3,
    LVL_LOLO    = 3'd4
  } tar_level_t;

  typedef enum logic [1:0] {
    NOTIFY_NONE     = 2'd0,
    NOTIFY_TEMP     = 2'd1,
    NOTIFY_READ_ERR = 2'd2
  } tar_notify_t;

  typedef enum logic [0:0] {
    ACT_SAMPLE    = 1'b0,
    ACT_READ_FAIL = 1'b1
  } tar_action_t;

  // Register map
  localparam logic [2:0] REG_HIHI_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HI_THRESHOLD   = 3'd1;
  localparam logic [2:0] REG_LOLO_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_LO_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_RISE_MARGIN    = 3'd4;
  localparam logic [2:0] REG_FAIL_LIMIT     = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [7:0] HIHI_RST   = 8'd75;
  localparam logic [7:0] HI_RST     = 8'd65;
  localparam logic [7:0] LOLO_RST   = 8'd15;
  localparam logic [7:0] LO_RST     = 8'd5;
  localparam logic [7:0] MARGIN_RST = 8'd1;
  localparam logic [3:0] LIMIT_RST  = 4'd3;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] hihi_threshold;
    logic [7:0] hi_threshold;
    logic [7:0] lolo_threshold;
    logic [7:0] lo_threshold;
    logic [7:0] rise_margin;
    logic [3:0] fail_limit;
  } tar_cfg_t;

  typedef struct packed {
    tar_level_t level;
    logic [7:0] last_mag;
    logic [3:0] fail_cnt;
    logic       halted;
  } tar_state_t;

  typedef struct packed {
    tar_notify_t notify;
    tar_level_t  alarm_level;
    logic [7:0]  report_magnitude;
    logic        report_negative;
    logic [7:0]  report_fraction;
    logic [15:0] report_raw;
    logic [3:0]  fail_run;
    logic        give_up;
  } tar_result_t;

endpackage

FILE: src/tar_step.sv
module tar_step
  import tar_pkg::*;
(
  input  tar_cfg_t    cfg,
  input  tar_state_t  state,
  input  logic        action,
  input  logic [7:0]  temp_magnitude,
  input  logic        temp_negative,
  input  logic [7:0]  temp_fraction,
  input  logic [15:0] raw_reading,
  output tar_state_t  state_nxt,
  output tar_result_t result
);

  tar_level_t  lvl;
  logic [8:0]  rise;
  logic        rise_hit;
  logic [3:0]  lim;
  logic [3:0]  cnt_inc;
  tar_notify_t notify;

  // Level of the incoming sample
  always_comb begin
    if (!temp_negative) begin
      if (temp_magnitude >= cfg.hihi_threshold)    lvl = LVL_HIHI;
      else if (temp_magnitude >= cfg.hi_threshold) lvl = LVL_HI;
      else                                         lvl = LVL_NOMINAL;
    end else begin
      if (temp_magnitude >= cfg.lolo_threshold)    lvl = LVL_LOLO;
      else if (temp_magnitude >= cfg.lo_threshold) lvl = LVL_LO;
      else                                         lvl = LVL_NOMINAL;
    end
  end

  // Borrow bit set means no rise at all
  assign rise     = {1'b0, temp_magnitude} - {1'b0, state.last_mag};
  assign rise_hit = !rise[8] && (rise[7:0] > cfg.rise_margin);

  assign lim     = (cfg.fail_limit == 4'd0) ? 4'd1 : cfg.fail_limit;
  assign cnt_inc = (state.fail_cnt < FAIL_MAX) ? state.fail_cnt + 4'd1 : state.fail_cnt;

  always_comb begin
    state_nxt = state;
    notify    = NOTIFY_NONE;
    if (!state.halted) begin
      if (action == ACT_SAMPLE) begin
        state_nxt.fail_cnt = 4'd0;
        if (lvl != state.level) begin
          state_nxt.level    = lvl;
          state_nxt.last_mag = temp_magnitude;
          notify             = NOTIFY_TEMP;
        end else if (state.level != LVL_NOMINAL && rise_hit) begin
          state_nxt.last_mag = temp_magnitude;
          notify             = NOTIFY_TEMP;
        end
      end else begin
        if (state.fail_cnt == 4'd0) begin
          state_nxt.level    = LVL_NOMINAL;
          state_nxt.last_mag = 8'd0;
          notify             = NOTIFY_READ_ERR;
        end
        state_nxt.fail_cnt = cnt_inc;
        if (cnt_inc >= lim) state_nxt.halted = 1'b1;
      end
    end
  end

  always_comb begin
    result.notify           = notify;
    result.alarm_level      = state_nxt.level;
    result.report_magnitude = 8'd0;
    result.report_negative  = 1'b0;
    result.report_fraction  = 8'd0;
    result.report_raw       = 16'd0;
    result.fail_run         = state_nxt.fail_cnt;
    result.give_up          = state_nxt.halted;
    if (notify == NOTIFY_TEMP) begin
      result.report_magnitude = temp_magnitude;
      result.report_negative  = temp_negative;
      result.report_fraction  = temp_fraction;
      result.report_raw       = raw_reading;
    end
  end

endmodule

FILE: src/temperature_alarm_reporter.sv
// A request accepted at a clock edge is captured in the result register at that edge and shows on out_*.
// Throughput: one request per cycle; in_ready stays high while the result register is empty or
//   being drained, so the input is only held off when out_valid is high and out_ready is low.
// Reset (rst_n low, synchronous): alarm state and failure count cleared, halt flag cleared,
//   thresholds, rise margin and failure limit back to their defaults, result register emptied.
module temperature_alarm_reporter
  import tar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_temp_magnitude,
  input  logic                  in_temp_negative,
  input  logic [7:0]            in_temp_fraction,
  input  logic [15:0]           in_raw_reading,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_notify,
  output logic [2:0]            out_alarm_level,
  output logic [7:0]            out_report_magnitude,
  output logic                  out_report_negative,
  output logic [7:0]            out_report_fraction,
  output logic [15:0]           out_report_raw,
  output logic [3:0]            out_fail_run,
  output logic                  out_give_up,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tar_cfg_t    cfg_r;
  tar_state_t  state_r, state_nxt;
  tar_result_t result, out_r;
  logic        out_valid_r;
  logic        in_fire;

  // The result register is the only buffer: the next request may enter in the same
  // cycle the current result leaves.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Register writes are always taken; unknown indexes fall through.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hihi_threshold <= HIHI_RST;
      cfg_r.hi_threshold   <= HI_RST;
      cfg_r.lolo_threshold <= LOLO_RST;
      cfg_r.lo_threshold   <= LO_RST;
      cfg_r.rise_margin    <= MARGIN_RST;
      cfg_r.fail_limit     <= LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HIHI_THRESHOLD: cfg_r.hihi_threshold <= cfg_data;
        REG_HI_THRESHOLD:   cfg_r.hi_threshold   <= cfg_data;
        REG_LOLO_THRESHOLD: cfg_r.lolo_threshold <= cfg_data;
        REG_LO_THRESHOLD:   cfg_r.lo_threshold   <= cfg_data;
        REG_RISE_MARGIN:    cfg_r.rise_margin    <= cfg_data;
        REG_FAIL_LIMIT:     cfg_r.fail_limit     <= cfg_data[3:0];
        default:            ;
      endcase
    end
  end

  // Classification, rise check and failure bookkeeping, all in one pass.
  tar_step u_step (
    .cfg            (cfg_r),
    .state          (state_r),
    .action         (in_action),
    .temp_magnitude (in_temp_magnitude),
    .temp_negative  (in_temp_negative),
    .temp_fraction  (in_temp_fraction),
    .raw_reading    (in_raw_reading),
    .state_nxt      (state_nxt),
    .result         (result)
  );

  // Alarm state moves on at acceptance so a back-to-back request sees it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.level    <= LVL_NOMINAL;
      state_r.last_mag <= 8'd0;
      state_r.fail_cnt <= 4'd0;
      state_r.halted   <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the result register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_notify           = out_r.notify;
  assign out_alarm_level      = out_r.alarm_level;
  assign out_report_magnitude = out_r.report_magnitude;
  assign out_report_negative  = out_r.report_negative;
  assign out_report_fraction  = out_r.report_fraction;
  assign out_report_raw       = out_r.report_raw;
  assign out_fail_run         = out_r.fail_run;
  assign out_give_up          = out_r.give_up;

  // Once halted, only a reset brings the block back.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt flag dropped without reset");

  // A halted block never issues a temperature report.
  a_no_temp_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_give_up) |-> (out_notify != NOTIFY_TEMP))
    else $error("temperature report with give-up set");

  // A read error report always starts a fresh run at nominal level.
  a_read_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify == NOTIFY_READ_ERR) |->
      (out_alarm_level == LVL_NOMINAL && out_fail_run == 4'd1))
    else $error("read error report with wrong level or count");

  // Report fields are blank unless a temperature report is issued.
  a_blank_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notify != NOTIFY_TEMP) |->
      (out_report_magnitude == 8'd0 && out_report_negative == 1'b0 &&
       out_report_fraction == 8'd0 && out_report_raw == 16'd0))
    else $error("report fields set without temperature report");

  // An accepted sample on a running block clears the failure run.
  a_sample_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_SAMPLE && !state_r.halted) |=> (state_r.fail_cnt == 4'd0))
    else $error("failure count not cleared by sample");

endmodule

FILE: tb/temperature_alarm_reporter_checker.sv
module temperature_alarm_reporter_checker
  import tar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_action,
  input  logic [7:0]            in_temp_magnitude,
  input  logic                  in_temp_negative,
  input  logic [7:0]            in_temp_fraction,
  input  logic [15:0]           in_raw_reading,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_notify,
  input  logic [2:0]            out_alarm_level,
  input  logic [7:0]            out_report_magnitude,
  input  logic                  out_report_negative,
  input  logic [7:0]            out_report_fraction,
  input  logic [15:0]           out_report_raw,
  input  logic [3:0]            out_fail_run,
  input  logic                  out_give_up,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    reports_seen,
  output int                    reports_open
);
  timeunit 1ns;
  timeprecision 1ps;

  tar_cfg_t    regs;
  tar_state_t  alarm;
  tar_result_t expected_reports[$];

  function automatic tar_level_t level_of(input logic [7:0] mag, input logic neg);
    if (!neg) begin
      if (mag >= regs.hihi_threshold) return LVL_HIHI;
      if (mag >= regs.hi_threshold) return LVL_HI;
      return LVL_NOMINAL;
    end
    if (mag >= regs.lolo_threshold) return LVL_LOLO;
    if (mag >= regs.lo_threshold) return LVL_LO;
    return LVL_NOMINAL;
  endfunction

  task automatic predict_report(input tar_action_t act, input logic [7:0] mag,
                                input logic neg, input logic [7:0] frac,
                                input logic [15:0] raw);
    tar_result_t r;
    tar_level_t  lvl;
    logic [3:0]  limit;
    r = '0;
    if (!alarm.halted) begin
      if (act == ACT_SAMPLE) begin
        lvl = level_of(mag, neg);
        alarm.fail_cnt = '0;
        if (lvl != alarm.level) begin
          alarm.level = lvl;
          alarm.last_mag = mag;
          r.notify = NOTIFY_TEMP;
        end else if (alarm.level != LVL_NOMINAL && mag > alarm.last_mag &&
                     (mag - alarm.last_mag) > regs.rise_margin) begin
          alarm.last_mag = mag;
          r.notify = NOTIFY_TEMP;
        end
      end else begin
        // zero limit behaves as one
        limit = (regs.fail_limit == 4'd0) ? 4'd1 : regs.fail_limit;
        if (alarm.fail_cnt == 4'd0) begin
          alarm.level = LVL_NOMINAL;
          alarm.last_mag = '0;
          r.notify = NOTIFY_READ_ERR;
        end
        if (alarm.fail_cnt < FAIL_MAX) alarm.fail_cnt = alarm.fail_cnt + 4'd1;
        if (alarm.fail_cnt >= limit) alarm.halted = 1'b1;
      end
    end
    r.alarm_level = alarm.level;
    if (r.notify == NOTIFY_TEMP) begin
      r.report_magnitude = mag;
      r.report_negative  = neg;
      r.report_fraction  = frac;
      r.report_raw       = raw;
    end
    r.fail_run = alarm.fail_cnt;
    r.give_up  = alarm.halted;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tar_result_t want;
    if (!rst_n) begin
      regs  = '{HIHI_RST, HI_RST, LOLO_RST, LO_RST, MARGIN_RST, LIMIT_RST};
      alarm = '{LVL_NOMINAL, 8'd0, 4'd0, 1'b0};
      expected_reports.delete();
      mismatches   = 0;
      reports_seen = 0;
    end else begin
      // results first: a result is registered, so it never belongs to a same-edge request
      if (out_valid && out_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("notify", want.notify, out_notify);
          check_field("alarm_level", want.alarm_level, out_alarm_level);
          check_field("report_magnitude", want.report_magnitude, out_report_magnitude);
          check_field("report_negative", want.report_negative, out_report_negative);
          check_field("report_fraction", want.report_fraction, out_report_fraction);
          check_field("report_raw", want.report_raw, out_report_raw);
          check_field("fail_run", want.fail_run, out_fail_run);
          check_field("give_up", want.give_up, out_give_up);
        end
      end
      if (in_valid && in_ready)
        predict_report(tar_action_t'(in_action), in_temp_magnitude, in_temp_negative,
                       in_temp_fraction, in_raw_reading);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIHI_THRESHOLD: regs.hihi_threshold = cfg_data;
          REG_HI_THRESHOLD:   regs.hi_threshold   = cfg_data;
          REG_LOLO_THRESHOLD: regs.lolo_threshold = cfg_data;
          REG_LO_THRESHOLD:   regs.lo_threshold   = cfg_data;
          REG_RISE_MARGIN:    regs.rise_margin    = cfg_data;
          REG_FAIL_LIMIT:     regs.fail_limit     = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    reports_open = expected_reports.size();
  end

endmodule

FILE: tb/temperature_alarm_reporter_tb.sv
module temperature_alarm_reporter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tar_pkg::*;

  // indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // handshake pacing per phase
  typedef enum int {
    PACE_FULL,        // no idling at all
    PACE_SEND_GAPS,   // sender idle 60% of cycles
    PACE_RECV_STALLS, // receiver stalls 60% of cycles
    PACE_BOTH_LIGHT   // both sides idle 6% of cycles
  } pace_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = 1'b0;
  logic [7:0]            in_temp_magnitude = '0;
  logic                  in_temp_negative = 1'b0;
  logic [7:0]            in_temp_fraction = '0;
  logic [15:0]           in_raw_reading = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_notify;
  logic [2:0]            out_alarm_level;
  logic [7:0]            out_report_magnitude;
  logic                  out_report_negative;
  logic [7:0]            out_report_fraction;
  logic [15:0]           out_report_raw;
  logic [3:0]            out_fail_run;
  logic                  out_give_up;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int reports_seen;
  int reports_open;

  pace_t pace = PACE_FULL;
  int    items_sent = 0;

  // stimulus shaping only: what was last written, how long the current failure run is
  logic [7:0] set_hihi = HIHI_RST;
  logic [7:0] set_hi   = HI_RST;
  logic [7:0] set_lolo = LOLO_RST;
  logic [7:0] set_lo   = LO_RST;
  int         fail_cap = int'(LIMIT_RST);
  int         fail_streak = 0;
  logic [7:0] last_mag = '0;
  logic       last_neg = 1'b0;

  temperature_alarm_reporter dut (.*);

  temperature_alarm_reporter_checker checker_i (.*);

  always #1 clk = ~clk;

  // receiver side: out_ready redrawn every cycle according to the pace
  always @(posedge clk) begin
    case (pace)
      PACE_RECV_STALLS: out_ready <= ($urandom_range(99) >= 60);
      PACE_BOTH_LIGHT:  out_ready <= ($urandom_range(99) >= 6);
      default:          out_ready <= 1'b1;
    endcase
  end

  // Drive one request and hold it until accepted. in_valid stays high when the
  // next request follows straight on; it only drops for a sender gap.
  task automatic send_request(input tar_action_t act, input logic [7:0] mag,
                              input logic neg, input logic [7:0] frac,
                              input logic [15:0] raw);
    int idle_pct;
    in_valid          <= 1'b1;
    in_action         <= act;
    in_temp_magnitude <= mag;
    in_temp_negative  <= neg;
    in_temp_fraction  <= frac;
    in_raw_reading    <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (act == ACT_READ_FAIL) begin
      fail_streak++;
    end else begin
      fail_streak = 0;
      last_mag = mag;
      last_neg = neg;
    end
    idle_pct = (pace == PACE_SEND_GAPS) ? 60 : (pace == PACE_BOTH_LIGHT) ? 6 : 0;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Mostly samples that sit near the thresholds or creep up inside a level,
  // with failure runs kept one short of the limit so the block never halts.
  task automatic send_random_request();
    tar_action_t act;
    logic        neg;
    logic [7:0]  aim;
    int          m;
    int          pick;
    act = ACT_SAMPLE;
    if ($urandom_range(99) < 12 && fail_streak + 1 < fail_cap) act = ACT_READ_FAIL;
    neg  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 35) begin
      // same side, small rise: exercises the rise margin
      neg = last_neg;
      m = int'(last_mag) + int'($urandom_range(4));
    end else if (pick < 75) begin
      if (neg) aim = $urandom_range(1) ? set_lolo : set_lo;
      else     aim = $urandom_range(1) ? set_hihi : set_hi;
      m = int'(aim) + int'($urandom_range(6)) - 3;
    end else if (pick < 85) begin
      m = $urandom_range(1) ? 255 : 0;
    end else begin
      m = $urandom_range(255);
    end
    if (m < 0) m = 0;
    if (m > 255) m = 255;
    send_request(act, m[7:0], neg, 8'($urandom_range(255)), 16'($urandom_range(65535)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Full register load, plus two writes to unmapped indexes. Only called when idle.
  task automatic load_regs(input logic [7:0] hihi, input logic [7:0] hi,
                           input logic [7:0] lolo, input logic [7:0] lo,
                           input logic [7:0] margin, input logic [7:0] limit);
    write_reg(REG_HIHI_THRESHOLD, hihi);
    write_reg(REG_SPARE_A, 8'($urandom_range(255)));
    write_reg(REG_HI_THRESHOLD, hi);
    write_reg(REG_LOLO_THRESHOLD, lolo);
    write_reg(REG_LO_THRESHOLD, lo);
    write_reg(REG_RISE_MARGIN, margin);
    write_reg(REG_SPARE_B, 8'($urandom_range(255)));
    write_reg(REG_FAIL_LIMIT, limit);
    cfg_valid <= 1'b0;
    set_hihi = hihi;
    set_hi   = hi;
    set_lolo = lolo;
    set_lo   = lo;
    // only the low nibble counts; zero acts as one
    fail_cap = (limit[3:0] == 4'd0) ? 1 : int'(limit[3:0]);
  endtask

  // stop sending and wait for every outstanding request's result
  task automatic drain();
    in_valid <= 1'b0;
    while (reports_seen < items_sent) @(posedge clk);
  endtask

  initial begin
    logic [7:0] hihi_v, hi_v, lolo_v, lo_v, margin_v, limit_v;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset thresholds (75/65/15/5, margin 1, limit 3) ---
    pace = PACE_FULL;
    send_request(ACT_SAMPLE, 8'd64, 1'b0, 8'h00, 16'h0000);  // one under hi: stays quiet
    send_request(ACT_SAMPLE, 8'd65, 1'b0, 8'h12, 16'h1234);  // enters hi
    send_request(ACT_SAMPLE, 8'd66, 1'b0, 8'h34, 16'h5678);  // rise equals margin: quiet
    send_request(ACT_SAMPLE, 8'd67, 1'b0, 8'h56, 16'h9ABC);  // rise beyond margin
    send_request(ACT_SAMPLE, 8'd75, 1'b0, 8'h78, 16'hDEF0);  // hihi
    send_request(ACT_SAMPLE, 8'd255, 1'b0, 8'hFF, 16'hFFFF);
    send_request(ACT_SAMPLE, 8'd254, 1'b0, 8'hAA, 16'h5555); // falling: quiet
    send_request(ACT_SAMPLE, 8'd5, 1'b1, 8'h55, 16'hAAAA);   // lo
    send_request(ACT_SAMPLE, 8'd14, 1'b1, 8'h01, 16'h0001);
    send_request(ACT_SAMPLE, 8'd15, 1'b1, 8'h80, 16'h8000);  // lolo
    send_request(ACT_SAMPLE, 8'd255, 1'b1, 8'hFF, 16'hFFFF);
    send_request(ACT_SAMPLE, 8'd0, 1'b0, 8'h00, 16'h0000);   // back to nominal
    send_request(ACT_READ_FAIL, 8'd33, 1'b1, 8'h44, 16'h4444); // read error
    send_request(ACT_READ_FAIL, 8'd0, 1'b0, 8'h00, 16'h0000);  // later failure: no report
    send_request(ACT_SAMPLE, 8'd20, 1'b1, 8'h0F, 16'h0F0F);  // sample clears count
    send_request(ACT_READ_FAIL, 8'd0, 1'b0, 8'h00, 16'h0000);  // read error drops lolo
    drain();

    // --- directed, extreme thresholds; limit written as 0xFF keeps only 15 ---
    pace = PACE_BOTH_LIGHT;
    load_regs(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_request(ACT_SAMPLE, 8'd0, 1'b1, 8'h11, 16'h2222);   // negative zero hits lo
    send_request(ACT_SAMPLE, 8'd0, 1'b0, 8'h33, 16'h4444);   // positive zero: nominal
    send_request(ACT_SAMPLE, 8'd255, 1'b0, 8'h66, 16'h7777); // hihi at the very top
    send_request(ACT_SAMPLE, 8'd255, 1'b1, 8'h99, 16'hCCCC); // lolo at the very top
    send_request(ACT_SAMPLE, 8'd254, 1'b1, 8'hEE, 16'h3333); // lo
    repeat (3) send_request(ACT_READ_FAIL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'($urandom_range(255)), 16'($urandom_range(65535)));
    drain();

    // --- random phases, a fresh register set each ---
    for (int phase = 0; phase < 6; phase++) begin
      pace   = pace_t'(phase % 4);
      lo_v   = 8'($urandom_range(60));
      lolo_v = lo_v + 8'($urandom_range(60));
      hi_v   = 8'($urandom_range(200, 40));
      hihi_v = hi_v + 8'($urandom_range(55));
      if ($urandom_range(3) == 0) begin
        // unordered thresholds now and then
        hihi_v = 8'($urandom_range(255));
        hi_v   = 8'($urandom_range(255));
        lolo_v = 8'($urandom_range(255));
        lo_v   = 8'($urandom_range(255));
      end
      case ($urandom_range(3))
        0:       margin_v = 8'h00;
        1:       margin_v = 8'hFF;
        default: margin_v = 8'($urandom_range(8));
      endcase
      limit_v[7:4] = 4'($urandom_range(15));
      limit_v[3:0] = 4'($urandom_range(15, 2));
      load_regs(hihi_v, hi_v, lolo_v, lo_v, margin_v, limit_v);
      repeat (250) send_random_request();
      drain();
    end

    // --- halt: limit of zero acts as one, so the first failure stops the block ---
    pace = PACE_RECV_STALLS;
    load_regs(HIHI_RST, HI_RST, LOLO_RST, LO_RST, MARGIN_RST, 8'hA0);
    send_request(ACT_SAMPLE, 8'd70, 1'b0, 8'h5A, 16'hA5A5);
    send_request(ACT_READ_FAIL, 8'd0, 1'b0, 8'h00, 16'h0000);  // read error with give_up
    // halted: everything ignored until reset
    repeat (10) send_request(tar_action_t'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1)), 8'($urandom_range(255)),
                             16'($urandom_range(65535)));
    drain();

    // catch any stray result
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_open == 0) begin
      $display("temperature_alarm_reporter: match");
    end else begin
      $display("temperature_alarm_reporter: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("temperature_alarm_reporter: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
src/tar_pkg.sv
src/tar_step.sv
src/temperature_alarm_reporter.sv
tb/temperature_alarm_reporter_checker.sv
tb/temperature_alarm_reporter_tb.sv
